FILE: rtl/core/bse_pkg.sv
// Types, codes and helper functions shared by the blend skinning engine.
`default_nettype none
package bse_pkg;

    localparam int WORD_W = 32;
    localparam int ACC_W  = 48;
    localparam int MUL_W  = 33;
    localparam int PROD_W = 66;
    localparam int SUM_W  = 68;
    localparam int SLOT_W = 5;

    localparam logic [1:0] CFG_TRANS_X = 2'd0;
    localparam logic [1:0] CFG_TRANS_Y = 2'd1;
    localparam logic [1:0] CFG_TRANS_Z = 2'd2;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_SKIN = 1'b1;

    localparam logic [1:0] ROW_LAST = 2'd2;
    localparam logic [1:0] ROW_BAD  = 2'd3;

    typedef struct packed {
        logic               action;
        logic [4:0]         joint;
        logic [4:0]         parent;
        logic [1:0]         row;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
        logic signed [31:0] operand_c;
        logic signed [31:0] operand_d;
        logic               last;
    } t_in;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               saturated;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ROOT,
        S_PREAD,
        S_WCOMP,
        S_TCOMP,
        S_ACOMP,
        S_WRITE,
        S_SKIN,
        S_FINAL,
        S_OUTW
    } t_state;

    // Slot of rotation entry n (row-major 3x3) in a joint's 4-wide row layout.
    function automatic logic [SLOT_W-1:0] f_rot_slot(input logic [3:0] n);
        logic [SLOT_W-1:0] s;
        case (n)
            4'd0:    s = 5'd0;
            4'd1:    s = 5'd1;
            4'd2:    s = 5'd2;
            4'd3:    s = 5'd4;
            4'd4:    s = 5'd5;
            4'd5:    s = 5'd6;
            4'd6:    s = 5'd8;
            4'd7:    s = 5'd9;
            4'd8:    s = 5'd10;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    // Parent fetch order: rotation, world translation, rest position.
    function automatic logic [SLOT_W-1:0] f_read_slot(input logic [4:0] n);
        logic [SLOT_W-1:0] s;
        if (n < 5'd9) begin
            s = f_rot_slot(n[3:0]);
        end else if (n < 5'd12) begin
            s = n + 5'd3;
        end else begin
            s = n + 5'd4;
        end
        return s;
    endfunction

    // Store order: rotation, adjusted translation, world translation, rest.
    function automatic logic [SLOT_W-1:0] f_write_slot(input logic [4:0] n);
        logic [SLOT_W-1:0] s;
        logic [4:0]        m;
        m = n - 5'd9;
        if (n < 5'd9) begin
            s = f_rot_slot(n[3:0]);
        end else if (n < 5'd12) begin
            s = {1'b0, m[1:0], 2'b11};
        end else if (n < 5'd15) begin
            s = n;
        end else begin
            s = n + 5'd1;
        end
        return s;
    endfunction

    function automatic logic f_ovf32(input logic signed [SUM_W-1:0] v);
        return !((&v[SUM_W-1:WORD_W-1]) || !(|v[SUM_W-1:WORD_W-1]));
    endfunction

    function automatic logic signed [WORD_W-1:0] f_sat32(input logic signed [SUM_W-1:0] v);
        logic signed [WORD_W-1:0] r;
        if (f_ovf32(v)) begin
            r = v[SUM_W-1] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
        end else begin
            r = v[WORD_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [ACC_W-1:0] f_sat48(input logic signed [SUM_W-1:0] v);
        logic signed [ACC_W-1:0] r;
        logic                    ok;
        ok = (&v[SUM_W-1:ACC_W-1]) || !(|v[SUM_W-1:ACC_W-1]);
        if (!ok) begin
            r = v[SUM_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            r = v[ACC_W-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/bse_ram.sv
// Generic simple dual-port RAM with one write port and a registered read.
`default_nettype none
module bse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 768
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

FILE: rtl/core/blend_skinning_engine.sv
// Linear blend skinning engine: joint transform builder and vertex blender.
//
//   channel   direction  handshake                 beat
//   in        input      i_in_valid / o_in_ready   t_in: one load row or one skin term
//   out       output     o_out_valid / i_out_ready t_out: one skinned point and flag
//   cfg       input      i_cfg_we                  global translation x, y or z
//
// One item is worked on at a time by a single 33x33 multiplier under a small
// sequencer; every multiply-accumulate passes through operand fetch, a
// registered product and the accumulate. A load of row 0 or 1 only stores
// the row; a root row 2 runs 9 MACs for the adjusted translation and 18
// writes, and a child row 2 runs the parent fetch, 27 MACs for the rotation,
// 9 each for translation and adjusted translation, and 18 writes.
// A skin term runs 12 MACs and a last term 9 more for the final transform.
// Reset is synchronous and clears the sequencer, the accumulator and the
// translation registers; the joint store holds garbage until it is loaded.
// A finished point waits in the output register; the block stalls only if a
// second point is ready before the first beat has been taken.
`default_nettype none
module blend_skinning_engine #(
    parameter int NUM_JOINTS = 24,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire bse_pkg::t_in  i_in,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output bse_pkg::t_out      o_out,
    input  wire logic          i_cfg_we,
    input  wire logic [1:0]    i_cfg_idx,
    input  wire logic [31:0]   i_cfg_data
);

    import bse_pkg::*;

    localparam int JW    = $clog2(NUM_JOINTS);
    localparam int AW    = JW + SLOT_W;
    localparam int DEPTH = NUM_JOINTS * (2 ** SLOT_W);
    localparam int NJW   = 8;
    localparam logic signed [PROD_W-1:0] RND_HALF =
        {{(PROD_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

    t_state r_state, n_state;
    logic [4:0] r_n, n_n;
    logic [1:0] r_i, n_i, r_c, n_c, r_k, n_k, r_ph, n_ph;

    t_in  r_in;
    t_out r_out;
    logic r_out_valid;
    logic r_flag;

    logic signed [WORD_W-1:0] r_trans [3];
    logic signed [WORD_W-1:0] r_pr [3][4];
    logic signed [WORD_W-1:0] r_pw [9];
    logic signed [WORD_W-1:0] r_pt [3];
    logic signed [WORD_W-1:0] r_pj [3];
    logic signed [WORD_W-1:0] r_w [9];
    logic signed [WORD_W-1:0] r_t [3];
    logic signed [WORD_W-1:0] r_a [3];
    logic signed [WORD_W-1:0] r_o [3];
    logic signed [ACC_W-1:0]  r_acc [12];
    logic signed [PROD_W-1:0] r_prod;
    logic signed [SUM_W-1:0]  r_sum;

    logic                     in_fire, in_jok, in_root, out_load, mac_end, acc_zero;
    logic [JW-1:0]            jsel, psel;
    logic [3:0]               idx_ik, idx_ic, acc_idx;
    logic signed [ACC_W-1:0]  acc_rd;
    logic signed [WORD_W-1:0] b_sat, vsel;
    logic                     b_ovf;
    logic signed [MUL_W-1:0]  ma, mb;
    logic signed [PROD_W-1:0] prod_full, prod_rnd;
    logic signed [SUM_W-1:0]  sum_next, sum_init, acc_new;
    logic                     ram_we;
    logic [AW-1:0]            ram_waddr, ram_raddr;
    logic [WORD_W-1:0]        ram_wdata, ram_rdata;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign in_jok      = NJW'(i_in.joint) < NJW'(NUM_JOINTS);
    assign in_root     = (i_in.joint == 5'd0) || !(NJW'(i_in.parent) < NJW'(NUM_JOINTS));
    assign out_load    = (r_state == S_OUTW) && (!r_out_valid || i_out_ready);
    assign mac_end     = (r_ph == 2'd2) && (r_k == 2'd2);
    assign jsel        = JW'(r_in.joint);
    assign psel        = JW'(r_in.parent);
    assign idx_ik      = {1'b0, r_i, 1'b0} + {2'b0, r_i} + {2'b0, r_k};
    assign idx_ic      = {1'b0, r_i, 1'b0} + {2'b0, r_i} + {2'b0, r_c};

    // The accumulator has one read port: the skin step reads the entry it
    // updates, the final pass reads the translation column first.
    always_comb begin
        if (r_state == S_SKIN) begin
            acc_idx = r_n[3:0];
        end else if (r_ph == 2'd0) begin
            acc_idx = {r_i, 2'b11};
        end else begin
            acc_idx = {r_i, r_k};
        end
    end

    assign acc_rd = r_acc[acc_idx];
    assign b_sat  = f_sat32(SUM_W'(acc_rd));
    assign b_ovf  = f_ovf32(SUM_W'(acc_rd));

    always_comb begin
        case (r_k)
            2'd0:    vsel = r_in.operand_a;
            2'd1:    vsel = r_in.operand_b;
            default: vsel = r_in.operand_c;
        endcase
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        case (r_state)
            S_WCOMP: begin
                ma = MUL_W'(r_pw[idx_ik]);
                mb = MUL_W'(r_pr[r_k][r_c]);
            end
            S_TCOMP: begin
                ma = MUL_W'(r_pw[idx_ik]);
                mb = MUL_W'(r_pr[r_k][3]) - MUL_W'(r_pj[r_k]);
            end
            S_ACOMP: begin
                ma = MUL_W'(r_w[idx_ik]);
                mb = MUL_W'(r_pr[r_k][3]);
            end
            S_SKIN: begin
                ma = MUL_W'(r_in.operand_d);
                mb = MUL_W'($signed(ram_rdata));
            end
            S_FINAL: begin
                ma = MUL_W'(b_sat);
                mb = MUL_W'(vsel);
            end
            default: begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    assign prod_full = ma * mb;
    assign prod_rnd  = (prod_full + RND_HALF) >>> FRAC_BITS;
    assign sum_next  = (r_state == S_ACOMP) ? r_sum - SUM_W'(r_prod) : r_sum + SUM_W'(r_prod);
    assign acc_new   = SUM_W'(acc_rd) + SUM_W'(r_prod);

    always_comb begin
        case (r_state)
            S_TCOMP: sum_init = SUM_W'(r_pt[r_i]);
            S_ACOMP: sum_init = SUM_W'(r_t[r_i]);
            S_FINAL: sum_init = SUM_W'(b_sat) + SUM_W'(r_trans[r_i]);
            default: sum_init = '0;
        endcase
    end

    // Joint store: per joint 32 slots, rows of [W | adj] at 0..11, world
    // translation at 12..14 and rest position at 16..18.
    assign ram_we    = (r_state == S_WRITE);
    assign ram_waddr = {jsel, f_write_slot(r_n)};
    assign ram_raddr = (r_state == S_SKIN) ? {jsel, r_n} : {psel, f_read_slot(r_n)};

    always_comb begin
        if (r_n < 5'd9) begin
            ram_wdata = r_w[r_n[3:0]];
        end else if (r_n < 5'd12) begin
            ram_wdata = r_a[2'(r_n - 5'd9)];
        end else if (r_n < 5'd15) begin
            ram_wdata = r_t[2'(r_n - 5'd12)];
        end else begin
            ram_wdata = r_pr[2'(r_n - 5'd15)][3];
        end
    end

    bse_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Sequencer.
    always_comb begin
        n_state = r_state;
        n_n     = r_n;
        n_i     = r_i;
        n_c     = r_c;
        n_k     = r_k;
        n_ph    = r_ph;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_in.action == ACT_LOAD) begin
                        if (in_jok && i_in.row == ROW_LAST) begin
                            n_state = in_root ? S_ROOT : S_PREAD;
                        end
                    end else if (in_jok) begin
                        n_state = S_SKIN;
                    end else if (i_in.last) begin
                        n_state = S_FINAL;
                    end
                end
            end
            S_ROOT: begin
                n_state = S_ACOMP;
            end
            S_PREAD: begin
                if (r_ph == 2'd0) begin
                    n_ph = 2'd1;
                end else begin
                    n_ph = 2'd0;
                    if (r_n == 5'd14) begin
                        n_n     = '0;
                        n_state = S_WCOMP;
                    end else begin
                        n_n = r_n + 5'd1;
                    end
                end
            end
            S_WCOMP, S_TCOMP, S_ACOMP, S_FINAL: begin
                if (r_ph != 2'd2) begin
                    n_ph = r_ph + 2'd1;
                end else begin
                    n_ph = 2'd0;
                    if (r_k != 2'd2) begin
                        n_k = r_k + 2'd1;
                    end else begin
                        n_k = 2'd0;
                        if (r_state == S_WCOMP && r_c != 2'd2) begin
                            n_c = r_c + 2'd1;
                        end else begin
                            n_c = 2'd0;
                            if (r_i != 2'd2) begin
                                n_i = r_i + 2'd1;
                            end else begin
                                n_i = 2'd0;
                                case (r_state)
                                    S_WCOMP: n_state = S_TCOMP;
                                    S_TCOMP: n_state = S_ACOMP;
                                    S_ACOMP: n_state = S_WRITE;
                                    default: n_state = S_OUTW;
                                endcase
                            end
                        end
                    end
                end
            end
            S_WRITE: begin
                if (r_n == 5'd17) begin
                    n_n     = '0;
                    n_state = S_IDLE;
                end else begin
                    n_n = r_n + 5'd1;
                end
            end
            S_SKIN: begin
                if (r_ph != 2'd2) begin
                    n_ph = r_ph + 2'd1;
                end else begin
                    n_ph = 2'd0;
                    if (r_n == 5'd11) begin
                        n_n     = '0;
                        n_state = r_in.last ? S_FINAL : S_IDLE;
                    end else begin
                        n_n = r_n + 5'd1;
                    end
                end
            end
            S_OUTW: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_n         <= '0;
            r_i         <= '0;
            r_c         <= '0;
            r_k         <= '0;
            r_ph        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
            r_i     <= n_i;
            r_c     <= n_c;
            r_k     <= n_k;
            r_ph    <= n_ph;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int q = 0; q < 3; q++) begin
                r_trans[q] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TRANS_X: r_trans[0] <= i_cfg_data;
                CFG_TRANS_Y: r_trans[1] <= i_cfg_data;
                CFG_TRANS_Z: r_trans[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Blend accumulator; cleared after the final pass has read it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int q = 0; q < 12; q++) begin
                r_acc[q] <= '0;
            end
        end else if (r_state == S_SKIN && r_ph == 2'd2) begin
            r_acc[r_n[3:0]] <= f_sat48(acc_new);
        end else if (r_state == S_FINAL && mac_end && r_i == 2'd2) begin
            for (int q = 0; q < 12; q++) begin
                r_acc[q] <= '0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in   <= i_in;
            r_flag <= 1'b0;
            if (i_in.action == ACT_LOAD && i_in.row != ROW_BAD && in_jok) begin
                r_pr[i_in.row][0] <= i_in.operand_a;
                r_pr[i_in.row][1] <= i_in.operand_b;
                r_pr[i_in.row][2] <= i_in.operand_c;
                r_pr[i_in.row][3] <= i_in.operand_d;
            end
        end
        if (r_ph == 2'd1) begin
            r_prod <= prod_rnd;
        end
        case (r_state)
            S_ROOT: begin
                for (int i = 0; i < 3; i++) begin
                    for (int c = 0; c < 3; c++) begin
                        r_w[i*3+c] <= r_pr[i][c];
                    end
                    r_t[i] <= r_pr[i][3];
                end
            end
            S_PREAD: begin
                if (r_ph == 2'd1) begin
                    if (r_n < 5'd9) begin
                        r_pw[r_n[3:0]] <= ram_rdata;
                    end else if (r_n < 5'd12) begin
                        r_pt[2'(r_n - 5'd9)] <= ram_rdata;
                    end else begin
                        r_pj[2'(r_n - 5'd12)] <= ram_rdata;
                    end
                end
            end
            S_WCOMP, S_TCOMP, S_ACOMP, S_FINAL: begin
                if (r_ph == 2'd0 && r_k == 2'd0) begin
                    r_sum <= sum_init;
                    if (r_state == S_FINAL && b_ovf) begin
                        r_flag <= 1'b1;
                    end
                end
                if (r_ph == 2'd1 && r_state == S_FINAL && b_ovf) begin
                    r_flag <= 1'b1;
                end
                if (r_ph == 2'd2) begin
                    r_sum <= sum_next;
                    if (r_k == 2'd2) begin
                        case (r_state)
                            S_WCOMP: r_w[idx_ic] <= f_sat32(sum_next);
                            S_TCOMP: r_t[r_i]    <= f_sat32(sum_next);
                            S_ACOMP: r_a[r_i]    <= f_sat32(sum_next);
                            default: begin
                                r_o[r_i] <= f_sat32(sum_next);
                                if (f_ovf32(sum_next)) begin
                                    r_flag <= 1'b1;
                                end
                            end
                        endcase
                    end
                end
            end
            S_OUTW: begin
                if (out_load) begin
                    r_out.out_x     <= r_o[0];
                    r_out.out_y     <= r_o[1];
                    r_out.out_z     <= r_o[2];
                    r_out.saturated <= r_flag;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        acc_zero = 1'b1;
        for (int q = 0; q < 12; q++) begin
            if (r_acc[q] != '0) begin
                acc_zero = 1'b0;
            end
        end
    end

    a_out_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (o_out_valid && r_state == S_IDLE))
        else $error("finished point not moved to the output register");

    a_acc_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINAL && n_state == S_OUTW) |=> acc_zero)
        else $error("blend accumulator not cleared after a point");

    a_counters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ph != 2'd3) && (r_k != 2'd3) && (r_i != 2'd3) && (r_n < 5'd18))
        else $error("sequencer counter out of range");

endmodule
`default_nettype wire
